### design/sitda_pkg.sv
// sitda_pkg: shared constants, state type and control and status structs for the
// signed integer to decimal text block. No dependencies.
package sitda_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int CHUNK_W         = 8;

    localparam logic [3:0] RADIX      = 4'd10;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_SIGN,
        S_DIGIT
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_div_ctrl;

    typedef struct packed {
        logic       last_step;
        logic       quot_zero;
        logic [3:0] digit;
    } t_div_stat;

endpackage

### design/signed_int_to_decimal_ascii.sv
// signed_int_to_decimal_ascii: top level, sequencer, digit store and output register.
// Depends on sitda_pkg and sitda_div10.
//
// Takes one signed VALUE_WIDTH-bit integer per input beat (i_value) and sends
// its decimal text as output beats of one character each, most significant
// first, with a leading '-' for negative values; zero gives "0". The final
// character of each value carries o_last_char.
// An input beat is taken when i_in_valid is high and o_in_stall is low; an
// output beat when o_out_valid is high and i_out_stall is low.
// After the input beat the magnitude goes through the divide-by-ten unit once
// per digit, one byte of the dividend a cycle, up to ten digits for a 32-bit
// value. Characters then load into the output register one per cycle, sign
// first, while the receiver does not stall. o_in_stall is high from the input
// beat until the last character has been loaded, so the next value is taken
// while the last character still waits. When the receiver stalls, the output
// register holds its character and the sequencer waits. Reset empties the
// output register and returns to idle.
module signed_int_to_decimal_ascii import sitda_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [7:0]                    o_character,
    output logic                          o_last_char
);

    localparam int NCHUNK = (VALUE_WIDTH + CHUNK_W - 1) / CHUNK_W;
    localparam int PAD_W  = NCHUNK * CHUNK_W;
    localparam int DIGITS = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
    localparam int IDX_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int CNT_W  = $clog2(DIGITS + 1);

    t_state             r_state;
    t_state             n_state;
    logic               r_neg;
    logic [CNT_W-1:0]   r_n;
    logic [CNT_W-1:0]   n_n;
    logic [3:0]         r_store [DIGITS];
    logic               r_out_valid;
    logic [7:0]         r_char;
    logic               r_last;

    logic [VALUE_WIDTH-1:0] mag;
    logic [CNT_W-1:0]       rd_pos;
    logic [IDX_W-1:0]       rd_idx;
    logic [IDX_W-1:0]       wr_idx;
    logic                   accept;
    logic                   out_free;
    logic                   out_load;
    logic [7:0]             out_char;
    logic                   out_last;
    logic                   store_we;
    t_div_ctrl              div_ctrl;
    t_div_stat              div_stat;

    assign mag      = i_value[VALUE_WIDTH-1] ? (VALUE_WIDTH'(0) - VALUE_WIDTH'(i_value))
                                             : VALUE_WIDTH'(i_value);
    assign accept   = i_in_valid & ~o_in_stall;
    assign out_free = ~r_out_valid | ~i_out_stall;
    assign rd_pos   = r_n - 1'b1;
    assign rd_idx   = rd_pos[IDX_W-1:0];
    assign wr_idx   = r_n[IDX_W-1:0];

    sitda_div10 #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_div10 (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (div_ctrl),
        .i_load_value (PAD_W'(mag)),
        .o_stat       (div_stat)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (div_stat.last_step && div_stat.quot_zero) begin
                    n_state = r_neg ? S_SIGN : S_DIGIT;
                end
            end
            S_SIGN: begin
                if (out_free) begin
                    n_state = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (out_free && (r_n == CNT_W'(1))) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_in_stall    = 1'b1;
        div_ctrl.load = 1'b0;
        div_ctrl.step = 1'b0;
        store_we      = 1'b0;
        out_load      = 1'b0;
        out_char      = CHAR_ZERO + {4'd0, r_store[rd_idx]};
        out_last      = (r_n == CNT_W'(1));
        n_n           = r_n;
        case (r_state)
            S_IDLE: begin
                o_in_stall    = 1'b0;
                div_ctrl.load = i_in_valid;
                if (i_in_valid) begin
                    n_n = '0;
                end
            end
            S_DIV: begin
                div_ctrl.step = 1'b1;
                store_we      = div_stat.last_step;
                if (div_stat.last_step) begin
                    n_n = r_n + 1'b1;
                end
            end
            S_SIGN: begin
                out_load = out_free;
                out_char = CHAR_MINUS;
                out_last = 1'b0;
            end
            S_DIGIT: begin
                out_load = out_free;
                if (out_free) begin
                    n_n = r_n - 1'b1;
                end
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_n         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_neg <= i_value[VALUE_WIDTH-1];
        end
        if (out_load) begin
            r_char <= out_char;
            r_last <= out_last;
        end
    end

    // digit store, least significant first
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[wr_idx] <= div_stat.digit;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_character = r_char;
    assign o_last_char = r_last;

endmodule

### design/sitda_div10.sv
// sitda_div10: iterative divide-by-ten unit, one byte of the dividend a cycle
// while step is high, quotient rotated back into the same register. Depends on sitda_pkg.
module sitda_div10 import sitda_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  t_div_ctrl                                        i_ctrl,
    input  logic [((VALUE_WIDTH+CHUNK_W-1)/CHUNK_W)*CHUNK_W-1:0] i_load_value,
    output t_div_stat                                        o_stat
);

    localparam int NCHUNK = (VALUE_WIDTH + CHUNK_W - 1) / CHUNK_W;
    localparam int PAD_W  = NCHUNK * CHUNK_W;
    localparam int CNT_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

    logic [PAD_W-1:0]   r_work;
    logic [PAD_W-1:0]   n_work;
    logic [3:0]         r_rem;
    logic [3:0]         step_rem;
    logic [CHUNK_W-1:0] step_q;
    logic [CNT_W-1:0]   r_cnt;
    logic               last;

    function automatic logic [CHUNK_W+3:0] chunk_div(input logic [3:0] rem_in,
                                                     input logic [CHUNK_W-1:0] chunk);
        logic [3:0]         rem;
        logic [4:0]         t;
        logic [CHUNK_W-1:0] q;
        rem = rem_in;
        q   = '0;
        for (int i = CHUNK_W - 1; i >= 0; i--) begin
            t = {rem, chunk[i]};
            if (t >= {1'b0, RADIX}) begin
                q[i] = 1'b1;
                rem  = 4'(t - {1'b0, RADIX});
            end else begin
                q[i] = 1'b0;
                rem  = t[3:0];
            end
        end
        return {rem, q};
    endfunction

    always_comb begin
        {step_rem, step_q} = chunk_div(r_rem, r_work[PAD_W-1 -: CHUNK_W]);
        n_work             = (r_work << CHUNK_W) | PAD_W'(step_q);
        last               = (r_cnt == CNT_W'(NCHUNK - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctrl.load) begin
            r_cnt <= '0;
        end else if (i_ctrl.step) begin
            r_cnt <= last ? '0 : r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_work <= i_load_value;
            r_rem  <= '0;
        end else if (i_ctrl.step) begin
            r_work <= n_work;
            r_rem  <= last ? 4'd0 : step_rem;
        end
    end

    assign o_stat.last_step = i_ctrl.step & last;
    assign o_stat.quot_zero = (n_work == '0);
    assign o_stat.digit     = step_rem;

endmodule

### design/sitda_checker.sv
// sitda_checker: port-level assertions for signed_int_to_decimal_ascii,
// bound to the top level. Depends on sitda_pkg.
module sitda_checker import sitda_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_character,
    input logic       o_last_char
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_character) && $stable(o_last_char))
        else $error("stalled output beat changed");

    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_character == CHAR_MINUS) ||
            ((o_character >= CHAR_ZERO) && (o_character <= CHAR_ZERO + 8'd9)))
        else $error("output character is neither sign nor digit");

    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_character == CHAR_MINUS) |-> !o_last_char)
        else $error("sign flagged as last character");

    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again straight after an input beat");

endmodule

bind signed_int_to_decimal_ascii sitda_checker u_sitda_checker (.*);
